// File: sv/tpf_pkg.sv
// ----------------------------------------------------------------------------
// tpf_pkg: shared types for the truncated Pareto frontier engine
// Operation codes, controller states, cost vector layout and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package tpf_pkg;

  localparam int COST_BITS = 32;
  localparam int VIN_BITS  = 6;
  localparam int SIZE_BITS = 5;
  localparam int FUNC_BITS = 2;

  typedef enum logic [FUNC_BITS-1:0] {
    FN_GLOBAL = 2'd0,
    FN_LOCAL  = 2'd1,
    FN_INSERT = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT,
    ST_FSCAN,
    ST_HSCAN,
    ST_REWRITE,
    ST_TAIL,
    ST_FINISH,
    ST_DONE
  } state_t;

  // first objective in the lowest bits
  typedef struct packed {
    logic [COST_BITS-1:0] third;
    logic [COST_BITS-1:0] second;
    logic [COST_BITS-1:0] first;
  } vec_t;

  typedef struct packed {
    logic clr_wr;     // clear one count entry
    logic take;       // capture the input word
    logic cnt_latch;  // latch the counts of the vertex
    logic scan_init;  // restart frontier and history scans
    logic fscan;      // frontier scan, check pass
    logic hscan;      // history scan
    logic rw_init;    // restart frontier for the rewrite pass
    logic rewrite;    // frontier rewrite pass
    logic tail_wr;    // write the last frontier element
    logic finish_wr;  // append history, store counts
    logic res_load;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic  clr_last;
    logic  fdone;
    logic  hdone;
    logic  found;
    logic  last_ok;
    logic  full;
    logic  out_busy;
    func_t func;
  } sts_t;

endpackage

// File: sv/tpf_ctrl.sv
// ----------------------------------------------------------------------------
// tpf_ctrl: operation sequencer
// Steps through count clear, count fetch, frontier scan, history scan,
// frontier rewrite and result hand-off.
// ----------------------------------------------------------------------------
module tpf_ctrl
  import tpf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = ST_CNT;
        end
      end
      ST_CNT: begin
        cmd.cnt_latch = 1'b1;
        cmd.scan_init = 1'b1;
        state_next    = (sts.func == FN_NOP) ? ST_DONE : ST_FSCAN;
      end
      ST_FSCAN: begin
        cmd.fscan = 1'b1;
        if (sts.fdone) begin
          case (sts.func)
            FN_LOCAL: begin
              state_next = (sts.found && !sts.last_ok) ? ST_HSCAN : ST_DONE;
            end
            FN_INSERT: begin
              if (sts.full) begin
                state_next = ST_DONE;
              end else begin
                cmd.rw_init = 1'b1;
                state_next  = ST_REWRITE;
              end
            end
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_HSCAN: begin
        cmd.hscan = 1'b1;
        if (sts.hdone) state_next = ST_DONE;
      end
      ST_REWRITE: begin
        cmd.rewrite = 1'b1;
        if (sts.fdone) state_next = ST_TAIL;
      end
      ST_TAIL: begin
        cmd.tail_wr = 1'b1;
        state_next  = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish_wr = 1'b1;
        state_next    = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

`ifndef ASSERT_OFF
  a_reset_clears: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> state == ST_CLEAR)
    else $error("controller left clear sweep too early");
  a_res_free: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> !sts.out_busy)
    else $error("result loaded over a pending word");
  a_rewrite_insert: assert property (@(posedge clk) disable iff (rst)
    state == ST_REWRITE |-> sts.func == FN_INSERT && !sts.full)
    else $error("rewrite without a fitting insert");
  a_global_short: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FSCAN && sts.fdone && sts.func == FN_GLOBAL) |=> state == ST_DONE)
    else $error("global check did not finish after frontier scan");
`endif

endmodule

// File: sv/tpf_dp.sv
// ----------------------------------------------------------------------------
// tpf_dp: frontier engine datapath
// Count, frontier and history memories, scan counters, dominance compares,
// the rewrite carry register and the result register.
// ----------------------------------------------------------------------------
module tpf_dp
  import tpf_pkg::*;
#(
  parameter int VERTICES  = 64,
  parameter int FRONT_CAP = 16,
  parameter int HIST_CAP  = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  input  logic [FUNC_BITS-1:0] in_func,
  input  logic [VIN_BITS-1:0]  in_vertex,
  input  vec_t                 in_vec,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_dom,
  output logic                 out_ovf,
  output logic [SIZE_BITS-1:0] out_size
);

  localparam int VW  = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int FCW = $clog2(FRONT_CAP + 1);
  localparam int HCW = $clog2(HIST_CAP + 1);
  localparam int FAW = $clog2(VERTICES * FRONT_CAP);
  localparam int HAW = $clog2(VERTICES * HIST_CAP);

  // memories
  vec_t           fmem   [VERTICES*FRONT_CAP];
  vec_t           hmem   [VERTICES*HIST_CAP];
  logic [FCW-1:0] cmem_f [VERTICES];
  logic [HCW-1:0] cmem_h [VERTICES];

  // operation registers
  func_t                func;
  logic [VW-1:0]        vx;
  vec_t                 v;
  logic [FCW-1:0]       fcnt, fk, w, o;
  logic [HCW-1:0]       hcnt, hk;
  logic [FCW-1:0]       cq_f;
  logic [HCW-1:0]       cq_h;
  logic                 found, hdom, ins, rd_v;
  logic [COST_BITS-1:0] last_first;
  vec_t                 hold, f_q, h_q;
  logic [VW-1:0]        clr_idx;

  logic [VW-1:0]  vx_in;
  logic [FAW-1:0] f_base, f_ra, f_wa;
  logic [HAW-1:0] h_base, h_ra, h_wa;
  logic           f_we;
  vec_t           f_wd;
  logic           covers, surv, lex_less, hit, full, res_dom;

  assign vx_in  = VW'(in_vertex % VERTICES);
  assign f_base = FAW'(vx) * FAW'(FRONT_CAP);
  assign h_base = HAW'(vx) * HAW'(HIST_CAP);
  assign f_ra   = f_base + FAW'(fk);
  assign h_ra   = h_base + HAW'(hk);
  assign f_wa   = f_base + FAW'(o);
  assign h_wa   = h_base + HAW'(hcnt);

  // compares against the entry just read
  assign covers   = (f_q.second <= v.second) && (f_q.third <= v.third);
  assign surv     = !((v.second <= f_q.second) && (v.third <= f_q.third));
  assign lex_less = (v.first < f_q.first) ||
                    ((v.first == f_q.first) && ((v.second < f_q.second) ||
                     ((v.second == f_q.second) && (v.third < f_q.third))));
  assign hit      = (h_q.first <= v.first) && (h_q.second <= v.second) &&
                    (h_q.third <= v.third);
  assign full     = (w >= FCW'(FRONT_CAP)) || (hcnt >= HCW'(HIST_CAP));

  // frontier write: rewrite stream or final element
  always_comb begin
    f_we = cmd.tail_wr || (cmd.rewrite && rd_v && surv);
    if (ins) begin
      f_wd = hold;
    end else if (cmd.tail_wr || lex_less) begin
      f_wd = v;
    end else begin
      f_wd = f_q;
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    f_q  <= fmem[f_ra];
    h_q  <= hmem[h_ra];
    cq_f <= cmem_f[vx_in];
    cq_h <= cmem_h[vx_in];
    if (f_we) fmem[f_wa] <= f_wd;
    if (cmd.finish_wr) hmem[h_wa] <= v;
    if (cmd.clr_wr) begin
      cmem_f[clr_idx] <= '0;
      cmem_h[clr_idx] <= '0;
    end else if (cmd.finish_wr) begin
      cmem_f[vx] <= FCW'(o + 1'b1);
      cmem_h[vx] <= HCW'(hcnt + 1'b1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx   <= '0;
      rd_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_idx <= clr_idx + 1'b1;
      if (cmd.scan_init || cmd.rw_init) begin
        rd_v <= 1'b0;
      end else if (cmd.fscan || cmd.rewrite) begin
        rd_v <= (fk < fcnt);
      end else if (cmd.hscan) begin
        rd_v <= (hk < hcnt);
      end else begin
        rd_v <= 1'b0;
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      func <= func_t'(in_func);
      vx   <= vx_in;
      v    <= in_vec;
    end
    if (cmd.cnt_latch) begin
      fcnt <= cq_f;
      hcnt <= cq_h;
    end
    if (cmd.scan_init) begin
      fk    <= '0;
      hk    <= '0;
      w     <= '0;
      found <= 1'b0;
      hdom  <= 1'b0;
    end else if (cmd.rw_init) begin
      fk  <= '0;
      o   <= '0;
      ins <= 1'b0;
    end else begin
      // advance read pointers
      if ((cmd.fscan || cmd.rewrite) && fk < fcnt) fk <= fk + 1'b1;
      if (cmd.hscan && hk < hcnt) hk <= hk + 1'b1;
      // check pass
      if (cmd.fscan && rd_v) begin
        if (covers) found <= 1'b1;
        w          <= w + FCW'(surv);
        last_first <= f_q.first;
      end
      // rewrite pass: drop covered entries, slot the new vector in
      if (cmd.rewrite && rd_v && surv) begin
        o <= o + 1'b1;
        if (ins || lex_less) begin
          ins  <= 1'b1;
          hold <= f_q;
        end
      end
      if (cmd.hscan && rd_v && hit) hdom <= 1'b1;
    end
  end

  // result word
  always_comb begin
    case (func)
      FN_GLOBAL: res_dom = found;
      FN_LOCAL:  res_dom = found && ((last_first <= v.first) || hdom);
      default:   res_dom = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_dom <= res_dom;
      out_ovf <= (func == FN_INSERT) && full;
      if (func == FN_INSERT && !full) begin
        out_size <= SIZE_BITS'(o + 1'b1);
      end else begin
        out_size <= SIZE_BITS'(fcnt);
      end
    end
  end

  // status
  always_comb begin
    sts.clr_last = (clr_idx == VW'(VERTICES - 1));
    sts.fdone    = (fk == fcnt) && !rd_v;
    sts.hdone    = (hk == hcnt) && !rd_v;
    sts.found    = found;
    sts.last_ok  = (last_first <= v.first);
    sts.full     = full;
    sts.out_busy = out_valid && !out_ready;
    sts.func     = func;
  end

endmodule

// File: sv/truncated_pareto_frontier_engine.sv
// ----------------------------------------------------------------------------
// truncated_pareto_frontier_engine: per-vertex Pareto frontier checks
// Global and local dominance checks and inserts against a sorted truncated
// frontier and an insert history kept for every graph vertex.
// ----------------------------------------------------------------------------
//  channel   direction  contents
//  s_*       in         tuser: func; tdata: vertex, cost_first..cost_third
//  m_*       out        tdata: dominated, overflow, frontier_size
//
//  Each word runs a frontier scan (the unused code skips it); a local check
//  that reaches the history adds a history scan, and an insert that fits
//  adds a frontier rewrite pass. A word is finished before the next is taken.
//  After reset a clearing pass zeroes the counts of every vertex; no word
//  is taken meanwhile. A waiting result word does not block the next input.
// ----------------------------------------------------------------------------
module truncated_pareto_frontier_engine
  import tpf_pkg::*;
#(
  parameter int VERTICES  = 64,
  parameter int FRONT_CAP = 16,
  parameter int HIST_CAP  = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [103:0] s_tdata,   // vertex, cost_first, cost_second, cost_third
  input  logic [1:0]   s_tuser,   // func
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [7:0]   m_tdata    // dominated, overflow, frontier_size
);

  cmd_t                 cmd;
  sts_t                 sts;
  vec_t                 in_vec;
  logic                 out_dom, out_ovf;
  logic [SIZE_BITS-1:0] out_size;

  assign in_vec.first  = s_tdata[37:6];
  assign in_vec.second = s_tdata[69:38];
  assign in_vec.third  = s_tdata[101:70];
  assign m_tdata       = {1'b0, out_size, out_ovf, out_dom};

  tpf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpf_dp #(
    .VERTICES  (VERTICES),
    .FRONT_CAP (FRONT_CAP),
    .HIST_CAP  (HIST_CAP)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_func   (s_tuser),
    .in_vertex (s_tdata[5:0]),
    .in_vec    (in_vec),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_dom   (out_dom),
    .out_ovf   (out_ovf),
    .out_size  (out_size)
  );

endmodule
